>>> design/sdr_pkg.sv
// ----------------------------------------------------------------------------
// sdr_pkg
// Shared constants and controller/datapath interface types for the
// stream duplicate remover.
// ----------------------------------------------------------------------------
package sdr_pkg;

  // field widths
  localparam int VALUE_W     = 32;
  localparam int COUNT_OUT_W = 7;

  // default table depth
  localparam int MAX_DISTINCT_DEFAULT = 64;

  // commands from controller to datapath
  typedef struct packed {
    logic load;    // latch a new transaction, restart the scan
    logic read;    // read the next table entry
    logic finish;  // decide, update the table, present the result
  } sdr_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic count_zero;  // table holds no entries
    logic scan_last;   // the read being issued is of the last stored entry
  } sdr_sts_t;

endpackage

>>> design/stream_duplicate_remover.sv
// ----------------------------------------------------------------------------
// stream_duplicate_remover
// Each transaction passes through an accept cycle, a scan of the N distinct
// values already stored for the current list (0 to MAX_DISTINCT), one stored
// entry per cycle through the table memory's single read port, and a
// decision cycle in which the result is registered. The result
// shows on the output ports for exactly one cycle with done high, and busy is
// already low in that cycle, so the next transaction may start then. The
// receiver cannot stall; results must be captured when done is high. After
// an element with last set the table is empty for the next list.
// ----------------------------------------------------------------------------
module stream_duplicate_remover #(
  parameter int MAX_DISTINCT = sdr_pkg::MAX_DISTINCT_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [sdr_pkg::VALUE_W-1:0]  value,
  input  logic                                last,
  output logic                                done,
  output logic signed [sdr_pkg::VALUE_W-1:0]  value_out,
  output logic                                keep,
  output logic [sdr_pkg::COUNT_OUT_W-1:0]     distinct_count,
  output logic                                table_overflow,
  output logic                                last_out
);
  import sdr_pkg::*;

  sdr_cmd_t cmd;
  sdr_sts_t sts;

  // sequencer
  sdr_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // table, compare and result registers
  sdr_datapath #(
    .MAX_DISTINCT (MAX_DISTINCT)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .value          (value),
    .last           (last),
    .done           (done),
    .value_out      (value_out),
    .keep           (keep),
    .distinct_count (distinct_count),
    .table_overflow (table_overflow),
    .last_out       (last_out)
  );

  // an accepted transaction always occupies the block next cycle
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("busy not raised after accepted transaction");

  // the result strobe comes with the block free again
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  // a repeated value never flags overflow
  assert property (@(posedge clk) disable iff (rst) (done && !keep) |-> !table_overflow)
    else $error("overflow on repeated value");

  // the table is empty once the last element of a list is reported
  assert property (@(posedge clk) disable iff (rst) (done && last_out) |-> sts.count_zero)
    else $error("table not cleared after last element");

endmodule

>>> design/sdr_ctrl.sv
// ----------------------------------------------------------------------------
// sdr_ctrl
// Sequencer for one transaction: accept, scan the stored entries one per
// cycle, then commit the decision.
// ----------------------------------------------------------------------------
module sdr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  sdr_pkg::sdr_sts_t sts,
  output sdr_pkg::sdr_cmd_t cmd,
  output logic              busy
);
  import sdr_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = sts.count_zero ? S_FINISH : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.read = 1'b1;
        if (sts.scan_last) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

>>> design/sdr_datapath.sv
// ----------------------------------------------------------------------------
// sdr_datapath
// Distinct-value table memory, scan compare, entry count and result
// registers.
// ----------------------------------------------------------------------------
module sdr_datapath #(
  parameter int MAX_DISTINCT = sdr_pkg::MAX_DISTINCT_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  sdr_pkg::sdr_cmd_t                   cmd,
  output sdr_pkg::sdr_sts_t                   sts,
  input  logic signed [sdr_pkg::VALUE_W-1:0]  value,
  input  logic                                last,
  output logic                                done,
  output logic signed [sdr_pkg::VALUE_W-1:0]  value_out,
  output logic                                keep,
  output logic [sdr_pkg::COUNT_OUT_W-1:0]     distinct_count,
  output logic                                table_overflow,
  output logic                                last_out
);
  import sdr_pkg::*;

  localparam int CntW = $clog2(MAX_DISTINCT + 1);
  localparam int IdxW = $clog2(MAX_DISTINCT);

  logic signed [VALUE_W-1:0] mem [MAX_DISTINCT];
  logic signed [VALUE_W-1:0] rd_data;
  logic signed [VALUE_W-1:0] cur_value;
  logic                      cur_last;
  logic [CntW-1:0]           count;
  logic [CntW-1:0]           count_next;
  logic [CntW-1:0]           count_after;
  logic [CntW-1:0]           rd_idx;
  logic                      cmp_valid;
  logic                      match;
  logic                      match_now;
  logic                      table_full;
  logic                      wr_en;

  // status to the controller
  assign sts.count_zero = (count == '0);
  assign sts.scan_last  = (rd_idx == CntW'(count - 1'b1));

  // table memory, one read and one write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count[IdxW-1:0]] <= cur_value;
    end
    if (cmd.read) begin
      rd_data <= mem[rd_idx[IdxW-1:0]];
    end
  end

  // transaction latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_value <= value;
      cur_last  <= last;
    end
  end

  // scan pointer, compare valid and match accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx    <= '0;
      cmp_valid <= 1'b0;
      match     <= 1'b0;
    end else begin
      cmp_valid <= cmd.read;
      if (cmd.load) begin
        rd_idx <= '0;
        match  <= 1'b0;
      end else begin
        if (cmd.read) begin
          rd_idx <= CntW'(rd_idx + 1'b1);
        end
        if (cmp_valid && (rd_data == cur_value)) begin
          match <= 1'b1;
        end
      end
    end
  end

  // decision on the final compare
  assign match_now   = match | (cmp_valid && (rd_data == cur_value));
  assign table_full  = (count >= CntW'(MAX_DISTINCT));
  assign wr_en       = cmd.finish && !match_now && !table_full;
  assign count_after = wr_en ? CntW'(count + 1'b1) : count;

  // entry count, cleared after the last element of a list
  always_comb begin
    count_next = count;
    if (cmd.finish) begin
      count_next = cur_last ? '0 : count_after;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      value_out      <= cur_value;
      keep           <= !match_now;
      distinct_count <= COUNT_OUT_W'(count_after);
      table_overflow <= !match_now && table_full;
      last_out       <= cur_last;
    end
  end

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: stream duplicate remover testbench
// Drives lists of signed 32-bit elements through the start/busy command port
// and checks every strobed result against an in-order duplicate filter kept
// in the scoreboard. Short directed lists hit the value extremes and repeats.
// Random lists then mix small pools with heavy repetition and large pools
// that can fill the table and run into overflow. Random gaps appear between
// transactions.
// ----------------------------------------------------------------------------
module tb_top;
  import sdr_pkg::*;

  localparam int TABLE_DEPTH  = MAX_DISTINCT_DEFAULT;
  localparam int TARGET_ITEMS = 700;
  localparam int CYCLE_LIMIT  = 1000000;

  typedef struct packed {
    logic [VALUE_W-1:0]     value;
    logic                   keep;
    logic [COUNT_OUT_W-1:0] count;
    logic                   overflow;
    logic                   last;
  } dedup_result_t;

  // in-order duplicate filter and the results it still owes
  class dedup_scoreboard;
    logic [VALUE_W-1:0] seen_values[$];
    dedup_result_t      owed_results[$];
    int unsigned        errors;
    int unsigned        n_elements;
    int unsigned        n_lists;
    int unsigned        n_kept;
    int unsigned        n_repeats;
    int unsigned        n_overflow;
    int unsigned        n_checked;

    function new();
      errors     = 0;
      n_elements = 0;
      n_lists    = 0;
      n_kept     = 0;
      n_repeats  = 0;
      n_overflow = 0;
      n_checked  = 0;
    endfunction

    // accepted element: work out its result and update the stored set
    function void note_element(logic [VALUE_W-1:0] v, logic l);
      dedup_result_t r;
      bit found;
      found = 1'b0;
      foreach (seen_values[i])
        if (seen_values[i] == v) found = 1'b1;
      r.value    = v;
      r.keep     = !found;
      r.overflow = 1'b0;
      r.last     = l;
      if (!found) begin
        // a full table passes the new value but does not store it
        if (seen_values.size() < TABLE_DEPTH) seen_values.push_back(v);
        else r.overflow = 1'b1;
      end
      r.count = COUNT_OUT_W'(seen_values.size());
      n_elements++;
      if (r.keep) n_kept++;
      else n_repeats++;
      if (r.overflow) n_overflow++;
      owed_results.push_back(r);
      // the count is reported before the end of the list clears the set
      if (l) begin
        seen_values.delete();
        n_lists++;
      end
    endfunction

    function void report(string field, logic [VALUE_W-1:0] exp_v,
                         logic [VALUE_W-1:0] act_v);
      errors++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, field, exp_v, act_v);
    endfunction

    // strobed result: compare with the oldest owed result
    function void check_result(logic [VALUE_W-1:0] v, logic k,
                               logic [COUNT_OUT_W-1:0] c, logic o, logic l);
      dedup_result_t r;
      if (owed_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none actual value %h", $time, v);
        return;
      end
      r = owed_results.pop_front();
      n_checked++;
      if (r.value !== v) report("value_out", r.value, v);
      if (r.keep !== k) report("keep", VALUE_W'(r.keep), VALUE_W'(k));
      if (r.count !== c) report("distinct_count", VALUE_W'(r.count), VALUE_W'(c));
      if (r.overflow !== o) report("table_overflow", VALUE_W'(r.overflow), VALUE_W'(o));
      if (r.last !== l) report("last_out", VALUE_W'(r.last), VALUE_W'(l));
    endfunction

    function int unsigned owed();
      return owed_results.size();
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          start = 1'b0;
  logic signed [VALUE_W-1:0]     value = '0;
  logic                          last = 1'b0;
  logic                          busy;
  logic                          done;
  logic signed [VALUE_W-1:0]     value_out;
  logic                          keep;
  logic [COUNT_OUT_W-1:0]        distinct_count;
  logic                          table_overflow;
  logic                          last_out;

  dedup_scoreboard sb;
  int unsigned     items_sent = 0;
  int unsigned     cycles = 0;
  bit              back_to_back = 1'b0;

  stream_duplicate_remover #(.MAX_DISTINCT(TABLE_DEPTH)) DUT (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .value         (value),
    .last          (last),
    .done          (done),
    .value_out     (value_out),
    .keep          (keep),
    .distinct_count(distinct_count),
    .table_overflow(table_overflow),
    .last_out      (last_out)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  // monitor: accepted transactions and result strobes
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.note_element(value, last);
      if (done) sb.check_result(value_out, keep, distinct_count, table_overflow, last_out);
    end
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  // start low for the requested idle time, junk on the payload meanwhile
  task automatic idle(input int n);
    start <= 1'b0;
    value <= $urandom;
    last  <= 1'($urandom_range(0, 1));
    repeat (n) @(posedge clk);
  endtask

  // hold start until the block takes the transaction
  task automatic send_element(input logic [VALUE_W-1:0] v, input logic l);
    int gap;
    start <= 1'b1;
    value <= v;
    last  <= l;
    do @(posedge clk); while (busy);
    items_sent++;
    gap = back_to_back ? 0 : pick_gap();
    if (gap > 0) idle(gap);
  endtask

  function automatic logic [VALUE_W-1:0] extreme_value();
    case ($urandom_range(0, 3))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return '0;
      default: return '1;
    endcase
  endfunction

  // one random list drawn from a pool; large pools are first sent in order
  // so the table can fill and the surplus values overflow
  task automatic run_list(input bit big);
    logic [VALUE_W-1:0] pool[$];
    logic [VALUE_W-1:0] base;
    logic [VALUE_W-1:0] step;
    logic [VALUE_W-1:0] v;
    int pool_size;
    int len;
    base = $urandom;
    step = $urandom | 32'd1;
    if (big) begin
      pool_size = $urandom_range(60, 80);
      len = pool_size + $urandom_range(10, 60);
    end else begin
      pool_size = $urandom_range(1, 16);
      len = $urandom_range(1, 24);
    end
    for (int i = 0; i < pool_size; i++)
      pool.push_back(base ^ (VALUE_W'(i) * step));
    if (!big && $urandom_range(0, 3) == 0) pool[0] = extreme_value();
    back_to_back = ($urandom_range(0, 4) == 0);
    for (int k = 0; k < len; k++) begin
      if (big && k < pool_size) v = pool[k];
      else if ($urandom_range(0, 9) == 0) v = $urandom;
      else v = pool[$urandom_range(0, pool_size - 1)];
      send_element(v, k == len - 1);
    end
    back_to_back = 1'b0;
  endtask

  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // single-element lists at both extremes
    send_element(32'h7FFF_FFFF, 1'b1);
    send_element(32'h8000_0000, 1'b1);
    // extremes with repeats inside one list
    send_element(32'h0000_0000, 1'b0);
    send_element(32'hFFFF_FFFF, 1'b0);
    send_element(32'h0000_0000, 1'b0);
    send_element(32'hFFFF_FFFF, 1'b0);
    send_element(32'h8000_0000, 1'b0);
    send_element(32'h7FFF_FFFF, 1'b0);
    send_element(32'h8000_0000, 1'b0);
    send_element(32'h0000_0001, 1'b1);
    // the same value over and over
    send_element(32'd5, 1'b0);
    send_element(32'd5, 1'b0);
    send_element(32'd5, 1'b1);
    // alternating bit patterns, values from the previous list start fresh
    send_element(32'hAAAA_AAAA, 1'b0);
    send_element(32'h5555_5555, 1'b0);
    send_element(32'd5, 1'b0);
    send_element(32'hAAAA_AAAA, 1'b1);

    // random lists, the first one from a large pool that can fill the table
    run_list(1'b1);
    while (items_sent < TARGET_ITEMS)
      run_list($urandom_range(0, 7) == 0);
    start <= 1'b0;

    // drain the outstanding results, then watch for stray strobes
    while (sb.owed() > 0) @(posedge clk);
    repeat (TABLE_DEPTH + 8) @(posedge clk);

    $display("covered %0d lists, %0d elements, %0d results checked", sb.n_lists,
             sb.n_elements, sb.n_checked);
    $display("kept %0d, repeats %0d, table overflows %0d", sb.n_kept, sb.n_repeats,
             sb.n_overflow);
    if (sb.errors == 0 && sb.owed() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
